// ===== hw/rtl/orsat_pkg.sv =====
// ----------------------------------------------------------------------------
// orsat_pkg: shared constants for the oriented rectangle overlap test
// Default widths, pipeline depths and the fixed-point constants of the
// sine and cosine series, including reciprocal multipliers for the
// constant divisors of each series term.
// ----------------------------------------------------------------------------
package orsat_pkg;

  localparam int COORD_BITS_DFLT     = 24;
  localparam int ANGLE_BITS_DFLT     = 16;
  localparam int TRIG_FRAC_BITS_DFLT = 16;

  localparam int TRIG_STAGES = 18;
  localparam int GEOM_STAGES = 4;
  localparam int SERIES_TERMS = 7;

  typedef logic [33:0] recip_t;

  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Term k divides by (2k)(2k+1) for sine and (2k-1)(2k) for cosine.
  localparam recip_t SIN_RECIP [1:7] = '{
    34'd11453246123, 34'd13743895348, 34'd13089424141, 34'd15270994831,
    34'd9995560253,  34'd14096302921, 34'd10471539313
  };
  localparam int SIN_SHIFT [1:7] = '{36, 38, 39, 40, 40, 41, 41};

  localparam recip_t COS_RECIP [1:7] = '{
    34'd8589934592,  34'd11453246123, 34'd9162596899,  34'd9817068106,
    34'd12216795865, 34'd16659267088, 34'd12082545361
  };
  localparam int COS_SHIFT [1:7] = '{34, 37, 38, 39, 40, 41, 41};

endpackage

// ===== hw/rtl/oriented_rect_overlap_sat_top.sv =====
// ----------------------------------------------------------------------------
// oriented_rect_overlap_sat_top: collision test of two oriented rectangles
// Takes one rectangle pair per item on the input channel and returns one
// collide flag per item on the output channel, in order.
//
// Usage: the input channel (in_valid, in_ready) carries both rectangles as
// centre, full width, full height and angle as a fraction of a turn. The
// output channel (out_valid, out_ready) carries collide, which is 1 when
// the rectangles overlap or touch.
// One item is accepted per cycle unless a stalled receiver has filled the
// pipeline; the pipeline has 23 stages, of which 18 stages form the sine
// and cosine series and 4 form the axis test.
// Each stage holds a valid bit and advances when the stage after it is
// empty or advancing, so a stalled receiver only stops the stages behind
// the held result and bubbles are squeezed out. Reset clears all valid
// bits; no item is in flight afterwards.
// ----------------------------------------------------------------------------
module oriented_rect_overlap_sat_top #(
  parameter int COORD_BITS     = orsat_pkg::COORD_BITS_DFLT,
  parameter int ANGLE_BITS     = orsat_pkg::ANGLE_BITS_DFLT,
  parameter int TRIG_FRAC_BITS = orsat_pkg::TRIG_FRAC_BITS_DFLT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] a_center_x,
  input  logic signed [COORD_BITS-1:0] a_center_y,
  input  logic [COORD_BITS-3:0]        a_width,
  input  logic [COORD_BITS-3:0]        a_height,
  input  logic [ANGLE_BITS-1:0]        a_angle,
  input  logic signed [COORD_BITS-1:0] b_center_x,
  input  logic signed [COORD_BITS-1:0] b_center_y,
  input  logic [COORD_BITS-3:0]        b_width,
  input  logic [COORD_BITS-3:0]        b_height,
  input  logic [ANGLE_BITS-1:0]        b_angle,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         collide
);

  localparam int TS  = orsat_pkg::TRIG_STAGES;
  localparam int GS  = orsat_pkg::GEOM_STAGES;
  localparam int NST = 1 + TS + GS;
  localparam int DW  = COORD_BITS + 1;
  localparam int SW  = COORD_BITS - 2;
  localparam int TW  = TRIG_FRAC_BITS + 2;

  logic [NST-1:0] vld, en;

  assign en        = ~vld | {out_ready, en[NST-1:1]};
  assign in_ready  = en[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (vld & ~en) | ({vld[NST-2:0], in_valid} & en);
    end
  end

  logic signed [DW-1:0] dx_d [0:TS];
  logic signed [DW-1:0] dy_d [0:TS];
  logic [SW-1:0]        wa_d [0:TS];
  logic [SW-1:0]        ha_d [0:TS];
  logic [SW-1:0]        wb_d [0:TS];
  logic [SW-1:0]        hb_d [0:TS];
  logic [ANGLE_BITS-1:0] a_ang, b_ang;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx_d[0] <= DW'(b_center_x) - DW'(a_center_x);
      dy_d[0] <= DW'(b_center_y) - DW'(a_center_y);
      wa_d[0] <= a_width;
      ha_d[0] <= a_height;
      wb_d[0] <= b_width;
      hb_d[0] <= b_height;
      a_ang   <= a_angle;
      b_ang   <= b_angle;
    end
  end

  for (genvar k = 1; k <= TS; k++) begin : g_carry
    always_ff @(posedge clk) begin
      if (en[k]) begin
        dx_d[k] <= dx_d[k-1];
        dy_d[k] <= dy_d[k-1];
        wa_d[k] <= wa_d[k-1];
        ha_d[k] <= ha_d[k-1];
        wb_d[k] <= wb_d[k-1];
        hb_d[k] <= hb_d[k-1];
      end
    end
  end

  logic signed [TW-1:0] sa, ca, sb, cb;

  orsat_trig #(
    .ANGLE_BITS     (ANGLE_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig_a (
    .clk     (clk),
    .en      (en[TS:1]),
    .angle   (a_ang),
    .sin_val (sa),
    .cos_val (ca)
  );

  orsat_trig #(
    .ANGLE_BITS     (ANGLE_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig_b (
    .clk     (clk),
    .en      (en[TS:1]),
    .angle   (b_ang),
    .sin_val (sb),
    .cos_val (cb)
  );

  orsat_geom #(
    .COORD_BITS     (COORD_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_geom (
    .clk     (clk),
    .en      (en[NST-1:TS+1]),
    .sa      (sa),
    .ca      (ca),
    .sb      (sb),
    .cb      (cb),
    .dx      (dx_d[TS]),
    .dy      (dy_d[TS]),
    .wa      (wa_d[TS]),
    .ha      (ha_d[TS]),
    .wb      (wb_d[TS]),
    .hb      (hb_d[TS]),
    .collide (collide)
  );

endmodule

// ===== hw/rtl/orsat_trig.sv =====
// ----------------------------------------------------------------------------
// orsat_trig: pipelined sine and cosine of a turn fraction
// Evaluates the Taylor series of both functions over the first quadrant,
// one multiply per stage, then clamps, rounds and applies the quadrant.
// ----------------------------------------------------------------------------
module orsat_trig #(
  parameter int ANGLE_BITS     = orsat_pkg::ANGLE_BITS_DFLT,
  parameter int TRIG_FRAC_BITS = orsat_pkg::TRIG_FRAC_BITS_DFLT
) (
  input  logic                                  clk,
  input  logic [orsat_pkg::TRIG_STAGES-1:0]     en,
  input  logic [ANGLE_BITS-1:0]                 angle,
  output logic signed [TRIG_FRAC_BITS+1:0]      sin_val,
  output logic signed [TRIG_FRAC_BITS+1:0]      cos_val
);

  localparam int RB = ANGLE_BITS - 2;
  localparam int T  = TRIG_FRAC_BITS;
  localparam int XW = 31;
  localparam int NW = 33;
  localparam int AW = 34;
  localparam int NT = orsat_pkg::SERIES_TERMS;
  localparam logic signed [AW-1:0] ONE_S = AW'(orsat_pkg::ONE_Q30);

  logic [XW-1:0] x0;
  logic [1:0]    q0;
  logic [RB+31:0] xprod;

  assign xprod = (RB+32)'(angle[RB-1:0]) * (RB+32)'(orsat_pkg::PI_Q30);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0 <= xprod[ANGLE_BITS-1 +: XW];
      q0 <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
    end
  end

  logic [XW-1:0]        ts   [0:NT];
  logic [XW-1:0]        tc   [0:NT];
  logic signed [AW-1:0] sacc [0:NT];
  logic signed [AW-1:0] cacc [0:NT];
  logic [31:0]          x2r  [0:NT];
  logic [1:0]           qd   [0:NT];
  logic [61:0]          x2full;

  assign x2full = 62'(x0) * 62'(x0);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x2r[0]  <= x2full[30 +: 32];
      ts[0]   <= x0;
      tc[0]   <= orsat_pkg::ONE_Q30;
      sacc[0] <= '0;
      cacc[0] <= '0;
      qd[0]   <= q0;
    end
  end

  for (genvar k = 1; k <= NT; k++) begin : g_term
    localparam bit NEG = ((k - 1) % 2) == 1;
    logic [NW-1:0]        ns, nc;
    logic signed [AW-1:0] sm, cm;
    logic [31:0]          x2m;
    logic [1:0]           qm;
    logic [62:0]          ps, pc;
    logic [79:0]          ds, dc;

    assign ps = 63'(ts[k-1]) * 63'(x2r[k-1]);
    assign pc = 63'(tc[k-1]) * 63'(x2r[k-1]);

    always_ff @(posedge clk) begin
      if (en[2*k]) begin
        ns  <= ps[30 +: NW];
        nc  <= pc[30 +: NW];
        x2m <= x2r[k-1];
        qm  <= qd[k-1];
        if (NEG) begin
          sm <= sacc[k-1] - AW'(ts[k-1]);
          cm <= cacc[k-1] - AW'(tc[k-1]);
        end else begin
          sm <= sacc[k-1] + AW'(ts[k-1]);
          cm <= cacc[k-1] + AW'(tc[k-1]);
        end
      end
    end

    assign ds = 80'(ns) * 80'(orsat_pkg::SIN_RECIP[k]);
    assign dc = 80'(nc) * 80'(orsat_pkg::COS_RECIP[k]);

    always_ff @(posedge clk) begin
      if (en[2*k+1]) begin
        ts[k]   <= ds[orsat_pkg::SIN_SHIFT[k] +: XW];
        tc[k]   <= dc[orsat_pkg::COS_SHIFT[k] +: XW];
        sacc[k] <= sm;
        cacc[k] <= cm;
        x2r[k]  <= x2m;
        qd[k]   <= qm;
      end
    end
  end

  logic signed [AW-1:0] sf, cf;
  logic [1:0]           qf;

  always_ff @(posedge clk) begin
    if (en[2*NT+2]) begin
      sf <= sacc[NT] - AW'(ts[NT]);
      cf <= cacc[NT] - AW'(tc[NT]);
      qf <= qd[NT];
    end
  end

  function automatic logic [T:0] rnd(input logic signed [AW-1:0] v);
    logic [30:0] c;
    logic [31:0] s;
    if (v < 0) begin
      c = '0;
    end else if (v > ONE_S) begin
      c = orsat_pkg::ONE_Q30;
    end else begin
      c = v[30:0];
    end
    s = {1'b0, c} + (32'd1 << (29 - T));
    return s[30-T +: T+1];
  endfunction

  logic signed [T+1:0] se, ce, sin_next, cos_next;

  assign se = $signed({1'b0, rnd(sf)});
  assign ce = $signed({1'b0, rnd(cf)});

  always_comb begin
    case (qf)
      2'd0: begin
        sin_next = se;
        cos_next = ce;
      end
      2'd1: begin
        sin_next = ce;
        cos_next = -se;
      end
      2'd2: begin
        sin_next = -se;
        cos_next = -ce;
      end
      default: begin
        sin_next = -ce;
        cos_next = se;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[2*NT+3]) begin
      sin_val <= sin_next;
      cos_val <= cos_next;
    end
  end

endmodule

// ===== hw/rtl/orsat_geom.sv =====
// ----------------------------------------------------------------------------
// orsat_geom: separating axis test on the four rectangle axes
// Forms axis dot products, projected center distances and projected
// half-extent sums, then compares them on every axis.
// ----------------------------------------------------------------------------
module orsat_geom #(
  parameter int COORD_BITS     = orsat_pkg::COORD_BITS_DFLT,
  parameter int TRIG_FRAC_BITS = orsat_pkg::TRIG_FRAC_BITS_DFLT
) (
  input  logic                              clk,
  input  logic [orsat_pkg::GEOM_STAGES-1:0] en,
  input  logic signed [TRIG_FRAC_BITS+1:0]  sa,
  input  logic signed [TRIG_FRAC_BITS+1:0]  ca,
  input  logic signed [TRIG_FRAC_BITS+1:0]  sb,
  input  logic signed [TRIG_FRAC_BITS+1:0]  cb,
  input  logic signed [COORD_BITS:0]        dx,
  input  logic signed [COORD_BITS:0]        dy,
  input  logic [COORD_BITS-3:0]             wa,
  input  logic [COORD_BITS-3:0]             ha,
  input  logic [COORD_BITS-3:0]             wb,
  input  logic [COORD_BITS-3:0]             hb,
  output logic                              collide
);

  localparam int T   = TRIG_FRAC_BITS;
  localparam int TW  = T + 2;
  localparam int DW  = COORD_BITS + 1;
  localparam int SW  = COORD_BITS - 2;
  localparam int MW  = 2*T + 2;
  localparam int PJW = DW + TW;
  localparam int CW  = COORD_BITS + 2*T + 4;
  localparam int EW  = SW + MW;

  logic signed [2*TW-1:0] pcc, pss, psc, pcs, caa, saa, cbb, sbb;
  logic signed [PJW-1:0]  dxca, dxsa, dyca, dysa, dxcb, dxsb, dycb, dysb;
  logic [SW-1:0]          wa1, ha1, wb1, hb1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pcc  <= ca * cb;
      pss  <= sa * sb;
      psc  <= sb * ca;
      pcs  <= cb * sa;
      caa  <= ca * ca;
      saa  <= sa * sa;
      cbb  <= cb * cb;
      sbb  <= sb * sb;
      dxca <= dx * ca;
      dxsa <= dx * sa;
      dyca <= dy * ca;
      dysa <= dy * sa;
      dxcb <= dx * cb;
      dxsb <= dx * sb;
      dycb <= dy * cb;
      dysb <= dy * sb;
      wa1  <= wa;
      ha1  <= ha;
      wb1  <= wb;
      hb1  <= hb;
    end
  end

  logic signed [2*TW:0] na_s, nb_s, d_s, x_s, d_a, x_a;
  logic signed [PJW:0]  pj_s [0:3];
  logic signed [PJW:0]  pj_a [0:3];

  assign na_s = (2*TW+1)'(caa) + (2*TW+1)'(saa);
  assign nb_s = (2*TW+1)'(cbb) + (2*TW+1)'(sbb);
  assign d_s  = (2*TW+1)'(pcc) + (2*TW+1)'(pss);
  assign x_s  = (2*TW+1)'(psc) - (2*TW+1)'(pcs);
  assign d_a  = d_s[2*TW] ? -d_s : d_s;
  assign x_a  = x_s[2*TW] ? -x_s : x_s;

  assign pj_s[0] = (PJW+1)'(dxca) + (PJW+1)'(dysa);
  assign pj_s[1] = (PJW+1)'(dyca) - (PJW+1)'(dxsa);
  assign pj_s[2] = (PJW+1)'(dxcb) + (PJW+1)'(dysb);
  assign pj_s[3] = (PJW+1)'(dycb) - (PJW+1)'(dxsb);

  logic [MW-1:0] na, nb, dm, xm;
  logic [CW-1:0] lhs1 [0:3];
  logic [SW-1:0] wa2, ha2, wb2, hb2;

  for (genvar i = 0; i < 4; i++) begin : g_proj
    assign pj_a[i] = pj_s[i][PJW] ? -pj_s[i] : pj_s[i];
    always_ff @(posedge clk) begin
      if (en[1]) begin
        lhs1[i] <= CW'(pj_a[i][PJW-1:0]) << (T + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      na  <= na_s[MW-1:0];
      nb  <= nb_s[MW-1:0];
      dm  <= d_a[MW-1:0];
      xm  <= x_a[MW-1:0];
      wa2 <= wa1;
      ha2 <= ha1;
      wb2 <= wb1;
      hb2 <= hb1;
    end
  end

  logic [EW-1:0] m_wna, m_hna, m_wnb, m_hnb, m_wad, m_wax, m_had, m_hax;
  logic [EW-1:0] m_wbd, m_wbx, m_hbd, m_hbx;
  logic [CW-1:0] lhs2 [0:3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      m_wna <= wa2 * na;
      m_hna <= ha2 * na;
      m_wnb <= wb2 * nb;
      m_hnb <= hb2 * nb;
      m_wad <= wa2 * dm;
      m_wax <= wa2 * xm;
      m_had <= ha2 * dm;
      m_hax <= ha2 * xm;
      m_wbd <= wb2 * dm;
      m_wbx <= wb2 * xm;
      m_hbd <= hb2 * dm;
      m_hbx <= hb2 * xm;
      lhs2  <= lhs1;
    end
  end

  logic [CW-1:0] rhs [0:3];
  logic          apart;

  assign rhs[0] = CW'(m_wna) + CW'(m_wbd) + CW'(m_hbx);
  assign rhs[1] = CW'(m_hna) + CW'(m_wbx) + CW'(m_hbd);
  assign rhs[2] = CW'(m_wad) + CW'(m_hax) + CW'(m_wnb);
  assign rhs[3] = CW'(m_wax) + CW'(m_had) + CW'(m_hnb);

  assign apart = (lhs2[0] > rhs[0]) || (lhs2[1] > rhs[1]) ||
                 (lhs2[2] > rhs[2]) || (lhs2[3] > rhs[3]);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      collide <= !apart;
    end
  end

endmodule
